FILE: hdl/sbod_pkg.sv
// ----------------------------------------------------------------------------
// sbod_pkg
// Shared types and constants for the spectral band onset detector.
// ----------------------------------------------------------------------------
`default_nettype none

package sbod_pkg;

    localparam int NUM_BANDS_DEF        = 16;
    localparam int BUCKETS_PER_BAND_DEF = 1;
    localparam int VALUE_WIDTH_DEF      = 16;

    localparam int RATIO_W     = 8;
    localparam int MASK_W      = 16;
    localparam int CFG_INDEX_W = 8;

    localparam logic [RATIO_W-1:0] NUM_RESET = 8'd5;
    localparam logic [RATIO_W-1:0] DEN_RESET = 8'd4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RATIO_NUM = 8'd0,
        CFG_RATIO_DEN = 8'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [RATIO_W-1:0] num;
        logic [RATIO_W-1:0] den;
    } ratio_cfg_t;

endpackage

`default_nettype wire

FILE: hdl/sbod_band_eval.sv
// ----------------------------------------------------------------------------
// sbod_band_eval
// Per-band update: loads or lowers the running minimum and tests the rise ratio
// (cur - min) * den > (prev - min) * num by cross multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module sbod_band_eval #(
    parameter int VALUE_WIDTH = sbod_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic [VALUE_WIDTH-1:0] cur,
    input  wire logic [VALUE_WIDTH-1:0] min_old,
    input  wire logic [VALUE_WIDTH-1:0] prev,
    input  wire logic                   primed,
    input  wire sbod_pkg::ratio_cfg_t   ratio,
    output logic      [VALUE_WIDTH-1:0] min_new,
    output logic                        hit
);

    localparam int PROD_W = VALUE_WIDTH + sbod_pkg::RATIO_W;

    logic [VALUE_WIDTH-1:0] rise;
    logic [VALUE_WIDTH-1:0] base;
    logic [PROD_W-1:0]      lhs;
    logic [PROD_W-1:0]      rhs;

    always_comb
    begin
        if (!primed || (cur < min_old))
        begin
            min_new = cur;
        end
        else
        begin
            min_new = min_old;
        end
        rise = cur - min_new;
        base = (prev >= min_new) ? (prev - min_new) : '0;
        lhs  = PROD_W'(rise) * PROD_W'(ratio.den);
        rhs  = PROD_W'(base) * PROD_W'(ratio.num);
        hit  = primed && (lhs > rhs);
    end

endmodule

`default_nettype wire

FILE: hdl/spectral_band_onset_detector_core.sv
// The word that closes a frame shows its mask on onset_* after acceptance
// through the band register stage, then the output register.
// Throughput: one bucket word per cycle; input stalls only when a finished
// mask meets a still-unread mask in the output register.
// Reset: clears control, ratio registers to 5/4, and restarts the priming frame.
// Band memories need no clear: the priming frame writes every entry first.
// ----------------------------------------------------------------------------
// spectral_band_onset_detector_core
// Sums buckets into bands, tracks per-band minimum and previous value, and
// emits one onset mask per frame after the priming frame.
// ----------------------------------------------------------------------------
`default_nettype none

module spectral_band_onset_detector_core #(
    parameter int NUM_BANDS        = sbod_pkg::NUM_BANDS_DEF,
    parameter int BUCKETS_PER_BAND = sbod_pkg::BUCKETS_PER_BAND_DEF,
    parameter int VALUE_WIDTH      = sbod_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             bucket_valid,
    output logic                                  bucket_ready,
    input  wire logic [VALUE_WIDTH-1:0]           bucket_value,

    output logic                                  onset_valid,
    input  wire logic                             onset_ready,
    output logic [sbod_pkg::MASK_W-1:0]           onset_mask,

    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [sbod_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sbod_pkg::RATIO_W-1:0]     cfg_data
);

    localparam int BAND_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int POS_W  = (BUCKETS_PER_BAND > 1) ? $clog2(BUCKETS_PER_BAND) : 1;
    localparam int MASK_W = sbod_pkg::MASK_W;

    // config
    sbod_pkg::ratio_cfg_t ratio_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg.num <= sbod_pkg::NUM_RESET;
            ratio_reg.den <= sbod_pkg::DEN_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == sbod_pkg::CFG_RATIO_NUM)
            begin
                ratio_reg.num <= cfg_data;
            end
            else if (cfg_index == sbod_pkg::CFG_RATIO_DEN)
            begin
                ratio_reg.den <= cfg_data;
            end
        end
    end

    // stage 1: band accumulation
    logic [VALUE_WIDTH-1:0] acc_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [BAND_W-1:0]      band_reg;
    logic                   primed_reg;

    // stage 2: band evaluation
    logic                   s2_valid_reg;
    logic [BAND_W-1:0]      s2_band_reg;
    logic [VALUE_WIDTH-1:0] s2_cur_reg;
    logic                   s2_primed_reg;
    logic                   s2_last_reg;
    logic [VALUE_WIDTH-1:0] min_rd_reg;
    logic [VALUE_WIDTH-1:0] prev_rd_reg;
    logic [MASK_W-1:0]      mask_builder_reg;

    // output
    logic                   out_valid_reg;
    logic [MASK_W-1:0]      onset_mask_reg;

    logic [VALUE_WIDTH-1:0] min_mem  [NUM_BANDS];
    logic [VALUE_WIDTH-1:0] prev_mem [NUM_BANDS];

    logic                   s2_emit;
    logic                   s2_blocked;
    logic                   adv;
    logic                   accept;
    logic [VALUE_WIDTH-1:0] acc_sum;
    logic                   band_done;
    logic                   frame_last;
    logic                   fwd;
    logic [VALUE_WIDTH-1:0] min_new;
    logic                   hit;
    logic [MASK_W-1:0]      hit_bits;
    logic [6:0]             s2_band_ext;

    assign s2_emit    = s2_valid_reg && s2_last_reg && s2_primed_reg;
    assign s2_blocked = s2_emit && out_valid_reg && !onset_ready;
    assign adv        = !s2_blocked;
    assign bucket_ready = adv;
    assign accept     = bucket_valid && adv;

    assign acc_sum    = acc_reg + bucket_value;
    assign band_done  = (pos_reg == POS_W'(BUCKETS_PER_BAND - 1));
    assign frame_last = (band_reg == BAND_W'(NUM_BANDS - 1));
    assign fwd        = s2_valid_reg && (s2_band_reg == band_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            pos_reg    <= '0;
            band_reg   <= '0;
            primed_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (band_done)
            begin
                acc_reg <= '0;
                pos_reg <= '0;
                if (frame_last)
                begin
                    band_reg   <= '0;
                    primed_reg <= 1'b1;
                end
                else
                begin
                    band_reg <= band_reg + 1'b1;
                end
            end
            else
            begin
                acc_reg <= acc_sum;
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    // band memory read, with bypass of the write in flight
    always_ff @(posedge clk)
    begin
        if (accept && band_done)
        begin
            if (fwd)
            begin
                min_rd_reg  <= min_new;
                prev_rd_reg <= s2_cur_reg;
            end
            else
            begin
                min_rd_reg  <= min_mem[band_reg];
                prev_rd_reg <= prev_mem[band_reg];
            end
            s2_band_reg   <= band_reg;
            s2_cur_reg    <= acc_sum;
            s2_primed_reg <= primed_reg;
            s2_last_reg   <= frame_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && adv)
        begin
            min_mem[s2_band_reg]  <= min_new;
            prev_mem[s2_band_reg] <= s2_cur_reg;
        end
    end

    sbod_band_eval #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_eval (
        .cur     (s2_cur_reg),
        .min_old (min_rd_reg),
        .prev    (prev_rd_reg),
        .primed  (s2_primed_reg),
        .ratio   (ratio_reg),
        .min_new (min_new),
        .hit     (hit)
    );

    // bands past the mask width are tracked but dropped from the mask
    assign s2_band_ext = 7'(s2_band_reg);

    always_comb
    begin
        for (int i = 0; i < MASK_W; i++)
        begin
            hit_bits[i] = hit && (s2_band_ext == 7'(i));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg     <= 1'b0;
            mask_builder_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            // a new mask takes the slot even while the old one is read
            out_valid_reg <= (adv && s2_emit) || (out_valid_reg && !onset_ready);
            if (adv)
            begin
                s2_valid_reg <= accept && band_done;
                if (s2_valid_reg)
                begin
                    if (s2_last_reg)
                    begin
                        mask_builder_reg <= '0;
                    end
                    else
                    begin
                        mask_builder_reg <= mask_builder_reg | hit_bits;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s2_emit)
        begin
            onset_mask_reg <= mask_builder_reg | hit_bits;
        end
    end

    assign onset_valid = out_valid_reg;
    assign onset_mask  = onset_mask_reg;

    // checks
    a_band_range: assert property (@(posedge clk) disable iff (!rst_n)
        band_reg <= BAND_W'(NUM_BANDS - 1))
        else $error("band index out of range");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(BUCKETS_PER_BAND - 1))
        else $error("bucket position out of range");

    a_no_mask_unprimed: assert property (@(posedge clk) disable iff (!rst_n)
        !primed_reg |-> !out_valid_reg)
        else $error("mask produced during priming frame");

    a_hold_on_block: assert property (@(posedge clk) disable iff (!rst_n)
        s2_blocked |=> s2_valid_reg && s2_last_reg)
        else $error("blocked final band lost");

endmodule

`default_nettype wire

FILE: verif/spectral_band_onset_detector_core_tb.sv
// ----------------------------------------------------------------------------
// spectral_band_onset_detector_core_tb
// Self-checking bench for the onset detector core. It sends bucket frames
// through the valid/ready input and rewrites the rise ratio between frames
// while the block is idle. Each onset mask is compared with a local model of
// the band minimum and previous-value tracking, or with the mask a table row
// gives. A short table of frames runs first: the priming frame, rail values,
// zero numerator, zero denominator and a 255/1 ratio. Random frames follow.
// Gaps and stalls are random on both sides.
// ----------------------------------------------------------------------------
module spectral_band_onset_detector_core_tb;

    localparam int NB          = sbod_pkg::NUM_BANDS_DEF;
    localparam int BPB         = sbod_pkg::BUCKETS_PER_BAND_DEF;
    localparam int VW          = sbod_pkg::VALUE_WIDTH_DEF;
    localparam int TOTAL_WORDS = 550;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic [VW-1:0]     value_t;
    typedef logic [sbod_pkg::MASK_W-1:0] mask_t;
    typedef logic [sbod_pkg::RATIO_W-1:0] ratio_t;

    typedef enum int {FILL_RANDOM, FILL_LOW, FILL_RAIL, FILL_RISE, FILL_HOLD} fill_t;

    typedef struct packed {
        bit            set_ratio;
        ratio_t        num;
        ratio_t        den;
        value_t        val_a;
        value_t        val_b;
        logic [NB-1:0] pick_b;
        bit            typed;
        mask_t         mask;
    } frame_row_t;

    localparam int DIRECTED_ROWS = 5;

    frame_row_t directed_rows [DIRECTED_ROWS] = '{
        // priming frame, no mask
        '{1'b0, 8'd0,   8'd0,   16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000},
        // rise from zero floor on every band
        '{1'b0, 8'd0,   8'd0,   16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, 16'hFFFF},
        // zero numerator: any value above the floor fires
        '{1'b1, 8'd0,   8'd255, 16'h0001, 16'h0000, 16'h5555, 1'b1, 16'hAAAA},
        // zero denominator: never fires
        '{1'b1, 8'd255, 8'd0,   16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, 16'h0000},
        '{1'b1, 8'd255, 8'd1,   16'h8000, 16'h7FFF, 16'h00FF, 1'b0, 16'h0000}
    };

    logic     clk          = 1'b0;
    logic     rst_n        = 1'b0;
    logic     bucket_valid = 1'b0;
    logic     bucket_ready;
    value_t   bucket_value = '0;
    logic     onset_valid;
    logic     onset_ready  = 1'b0;
    mask_t    onset_mask;
    logic     cfg_valid    = 1'b0;
    logic     cfg_ready;
    sbod_pkg::cfg_reg_t cfg_index = sbod_pkg::CFG_RATIO_NUM;
    ratio_t   cfg_data     = '0;

    // band tracking state
    ratio_t ratio_num = sbod_pkg::NUM_RESET;
    ratio_t ratio_den = sbod_pkg::DEN_RESET;
    value_t min_level [NB];
    value_t last_band [NB] = '{default: '0};
    value_t band_sum     = '0;
    int     bucket_count = 0;
    int     band_idx     = 0;
    bit     primed       = 1'b0;
    mask_t  mask_acc     = '0;

    mask_t  pending_masks [$];
    mask_t  want_mask;
    int     errors        = 0;
    int     cycle_count   = 0;
    int     words_sent    = 0;
    int     sink_stall    = 0;
    bit     steady_sender = 1'b0;
    bit     steady_sink   = 1'b0;

    spectral_band_onset_detector_core dut (.*);

    always #4 clk = ~clk;

    function automatic bit predict_onset(input value_t v, output mask_t m);
        bit        produced;
        bit [63:0] rise;
        bit [63:0] base;
        value_t    cur;
        produced = 1'b0;
        m = '0;
        band_sum = band_sum + v;
        bucket_count++;
        if (bucket_count < BPB)
            return 1'b0;
        cur = band_sum;
        band_sum = '0;
        bucket_count = 0;
        if (!primed)
            min_level[band_idx] = cur;
        else
        begin
            if (cur < min_level[band_idx])
                min_level[band_idx] = cur;
            rise = 64'(cur - min_level[band_idx]);
            base = (last_band[band_idx] >= min_level[band_idx]) ?
                   64'(last_band[band_idx] - min_level[band_idx]) : 64'd0;
            if (rise * ratio_den > base * ratio_num && band_idx < sbod_pkg::MASK_W)
                mask_acc[band_idx] = 1'b1;
        end
        last_band[band_idx] = cur;
        band_idx++;
        if (band_idx < NB)
            return 1'b0;
        band_idx = 0;
        if (primed)
        begin
            m = mask_acc;
            produced = 1'b1;
        end
        primed = 1'b1;
        mask_acc = '0;
        return produced;
    endfunction

    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_bucket(input value_t v, input bit typed, input mask_t typed_mask);
        mask_t m;
        int    gap;
        bucket_valid <= 1'b1;
        bucket_value <= v;
        @(posedge clk);
        while (!bucket_ready)
            @(posedge clk);
        words_sent++;
        if (predict_onset(v, m))
            pending_masks.push_back(typed ? typed_mask : m);
        gap = pick_gap(steady_sender);
        if (gap > 0)
        begin
            bucket_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_frame(input value_t band_val [NB], input bit typed,
                              input mask_t typed_mask);
        for (int b = 0; b < NB; b++)
            for (int j = 0; j < BPB; j++)
                send_bucket((j == 0) ? band_val[b] : value_t'(0), typed, typed_mask);
    endtask

    // hold the sender until every mask is back and the pipe is empty
    task automatic drain();
        bucket_valid <= 1'b0;
        while (pending_masks.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_ratios(input ratio_t num, input ratio_t den);
        cfg_valid <= 1'b1;
        cfg_index <= sbod_pkg::CFG_RATIO_NUM;
        cfg_data  <= num;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        ratio_num = num;
        cfg_index <= sbod_pkg::CFG_RATIO_DEN;
        cfg_data  <= den;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        ratio_den = den;
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (sink_stall > 0)
        begin
            onset_ready <= 1'b0;
            sink_stall  <= sink_stall - 1;
        end
        else
        begin
            onset_ready <= 1'b1;
            sink_stall  <= pick_gap(steady_sink);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && onset_valid && onset_ready)
        begin
            if (pending_masks.size() == 0)
            begin
                $display("%0t: onset_mask word %h with none expected", $time, onset_mask);
                errors++;
            end
            else
            begin
                want_mask = pending_masks.pop_front();
                if (onset_mask !== want_mask)
                begin
                    $display("%0t: onset_mask expected %h, actual %h",
                             $time, want_mask, onset_mask);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("spectral_band_onset_detector_core_tb: errors");
            $finish;
        end
    end

    initial
    begin
        value_t     vals [NB];
        frame_row_t row;
        fill_t      fill;
        int         r;
        int         frames;
        ratio_t     num;
        ratio_t     den;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = directed_rows[i];
            if (row.set_ratio)
            begin
                drain();
                set_ratios(row.num, row.den);
            end
            for (int b = 0; b < NB; b++)
                vals[b] = row.pick_b[b] ? row.val_b : row.val_a;
            send_frame(vals, row.typed, row.mask);
        end

        while (words_sent < TOTAL_WORDS)
        begin
            drain();
            r = $urandom_range(0, 7);
            case (r)
                0: begin num = sbod_pkg::NUM_RESET; den = sbod_pkg::DEN_RESET; end
                1: begin num = 8'd1;      den = 8'd255;    end
                2: begin num = 8'd255;    den = 8'd1;      end
                3: begin num = 8'd255;    den = 8'd255;    end
                4: begin num = 8'd1;      den = 8'd1;      end
                5: begin num = 8'd0;      den = ratio_t'($urandom_range(1, 255)); end
                6: begin num = ratio_t'($urandom_range(1, 255)); den = 8'd0;      end
                default:
                begin
                    num = ratio_t'($urandom_range(1, 255));
                    den = ratio_t'($urandom_range(1, 255));
                end
            endcase
            set_ratios(num, den);
            steady_sender = ($urandom_range(0, 3) == 0);
            steady_sink   = ($urandom_range(0, 3) == 0);
            frames = $urandom_range(1, 5);
            repeat (frames)
            begin
                r = $urandom_range(0, 9);
                if (r < 3)
                    fill = FILL_RANDOM;
                else if (r == 3)
                    fill = FILL_LOW;
                else if (r == 4)
                    fill = FILL_RAIL;
                else if (r < 8)
                    fill = FILL_RISE;
                else
                    fill = FILL_HOLD;
                for (int b = 0; b < NB; b++)
                    case (fill)
                        FILL_RANDOM: vals[b] = value_t'($urandom);
                        FILL_LOW:    vals[b] = value_t'($urandom_range(0, 15));
                        FILL_RAIL:   vals[b] = $urandom_range(0, 1) ? '1 : '0;
                        FILL_RISE:   vals[b] = last_band[b] + value_t'($urandom_range(0, 3000));
                        default:     vals[b] = last_band[b];
                    endcase
                send_frame(vals, 1'b0, '0);
            end
        end

        steady_sender = 1'b0;
        steady_sink   = 1'b0;
        drain();
        if (errors == 0)
            $display("spectral_band_onset_detector_core_tb: clean");
        else
            $display("spectral_band_onset_detector_core_tb: errors");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/sbod_pkg.sv
hdl/sbod_band_eval.sv
hdl/spectral_band_onset_detector_core.sv
verif/spectral_band_onset_detector_core_tb.sv
